// ----- rtl/core/cdfuk_pkg.sv -----
// Shared types, constants and helper functions for the clock digit formatter.
// No dependencies; used by cdfuk_summer and clock_digit_formatter_with_uk_dst.
`timescale 1ns / 1ps
`default_nettype none

package cdfuk_pkg;

   // Configuration register indexes (byte address is four times the index).
   localparam int unsigned CsrAddrWidth = 5;
   localparam logic [2:0] REG_MODE_24H     = 3'd0;
   localparam logic [2:0] REG_DST_ENABLE   = 3'd1;
   localparam logic [2:0] REG_COLON_ENABLE = 3'd2;
   localparam logic [2:0] REG_COLON_FLASH  = 3'd3;
   localparam logic [2:0] REG_LED_ENABLE   = 3'd4;

   // Calendar constants.
   localparam logic [3:0] MONTH_MAR       = 4'd3;
   localparam logic [3:0] MONTH_APR       = 4'd4;
   localparam logic [3:0] MONTH_SEP       = 4'd9;
   localparam logic [3:0] MONTH_OCT       = 4'd10;
   localparam logic [4:0] DAY_LAST        = 5'd31;
   localparam int unsigned ZellerBias     = 84;
   localparam logic [8:0] BASE_OFFSET     = 9'(31 + ZellerBias);
   // (13*mm - 1)/5 for March (mm = 1) and October (mm = 8).
   localparam logic [8:0] MONTH_TERM_MAR  = 9'd2;
   localparam logic [8:0] MONTH_TERM_OCT  = 9'd20;
   // year / 100 == (year * 5243) >> 19 for every 12-bit year.
   localparam logic [24:0] DIV100_MUL     = 25'd5243;
   localparam int unsigned Div100Shift    = 19;

   // Hour and minute limits.
   localparam logic [4:0] HOURS_PER_DAY   = 5'd24;
   localparam logic [4:0] HOUR_LAST       = 5'd23;
   localparam logic [4:0] HOUR_NOON       = 5'd12;
   localparam logic [4:0] HOUR_AM_LAST    = 5'd11;
   localparam logic [5:0] MINUTE_LAST     = 6'd59;

   // Per-request data carried beside the calendar pipeline.
   typedef struct packed {
      logic [4:0] hour;     // already wrapped into 0..23
      logic [5:0] minute;   // already saturated at 59
      logic       even;     // second is even
      logic       online;
   } side_type;

   // Residue modulo 7 of a 9-bit value, using 8 == 1 (mod 7).
   function automatic logic [2:0] mod7(input logic [8:0] x);
      logic [4:0] s;
      logic [3:0] t;
      s = {2'b00, x[8:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
      t = {2'b00, s[4:3]} + {1'b0, s[2:0]};
      mod7 = (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cdfuk_summer.sv -----
// Four-stage pipeline that decides UK summer time for a date.
// Depends on cdfuk_pkg for calendar constants and the modulo-7 helper.
`timescale 1ns / 1ps
`default_nettype none

module cdfuk_summer (
   input  wire logic        clock,
   input  wire logic        advance,
   input  wire logic [11:0] year,
   input  wire logic [3:0]  month,
   input  wire logic [4:0]  day,
   output logic             summer
);

   localparam logic [24:0] DIV100_MUL_LOCAL = cdfuk_pkg::DIV100_MUL;
   localparam int unsigned Div100ShiftLocal = cdfuk_pkg::Div100Shift;

   // Stage 1: century by reciprocal multiplication.
   logic [5:0]  cent1_ff;
   logic [5:0]  cent1_in;
   logic [11:0] year1_ff;
   logic [3:0]  month1_ff;
   logic [4:0]  day1_ff;
   logic [24:0] prod;

   // Stage 2: two-digit year.
   logic [6:0]  yy2_ff;
   logic [6:0]  yy2_in;
   logic [5:0]  cent2_ff;
   logic [3:0]  month2_ff;
   logic [4:0]  day2_ff;

   // Stage 3: weekday of the 31st in March and October.
   logic [2:0]  wd_mar3_ff;
   logic [2:0]  wd_mar3_in;
   logic [2:0]  wd_oct3_ff;
   logic [2:0]  wd_oct3_in;
   logic [3:0]  month3_ff;
   logic [4:0]  day3_ff;
   logic [8:0]  base;

   // Stage 4: decision.
   logic        summer4_ff;
   logic        summer4_in;

   always_comb begin
      prod     = {13'b0, year} * DIV100_MUL_LOCAL;
      cent1_in = prod[Div100ShiftLocal +: 6];
   end

   always_comb begin
      yy2_in = 7'(year1_ff - (12'(cent1_ff) * 12'd100));
   end

   always_comb begin
      base = {2'b00, yy2_ff} + {4'b0, yy2_ff[6:2]} + {5'b0, cent2_ff[5:2]}
             + cdfuk_pkg::BASE_OFFSET - {2'b00, cent2_ff, 1'b0};
      wd_mar3_in = cdfuk_pkg::mod7(base + cdfuk_pkg::MONTH_TERM_MAR);
      wd_oct3_in = cdfuk_pkg::mod7(base + cdfuk_pkg::MONTH_TERM_OCT);
   end

   always_comb begin
      summer4_in = 1'b0;
      if (month3_ff inside {[cdfuk_pkg::MONTH_APR:cdfuk_pkg::MONTH_SEP]}) begin
         summer4_in = 1'b1;
      end else if (month3_ff == cdfuk_pkg::MONTH_MAR) begin
         summer4_in = (day3_ff >= (cdfuk_pkg::DAY_LAST - {2'b00, wd_mar3_ff}));
      end else if (month3_ff == cdfuk_pkg::MONTH_OCT) begin
         summer4_in = (day3_ff < (cdfuk_pkg::DAY_LAST - {2'b00, wd_oct3_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cent1_ff   <= cent1_in;
         year1_ff   <= year;
         month1_ff  <= month;
         day1_ff    <= day;
         yy2_ff     <= yy2_in;
         cent2_ff   <= cent1_ff;
         month2_ff  <= month1_ff;
         day2_ff    <= day1_ff;
         wd_mar3_ff <= wd_mar3_in;
         wd_oct3_ff <= wd_oct3_in;
         month3_ff  <= month2_ff;
         day3_ff    <= day2_ff;
         summer4_ff <= summer4_in;
      end
   end

   assign summer = summer4_ff;

endmodule

`default_nettype wire

// ----- rtl/core/clock_digit_formatter_with_uk_dst.sv -----
// Path: a request accepted on req_* passes through the five register stages before its result shows on rsp_*.
// Throughput: one request per cycle; five register stages move together and hold on a stall.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset clears all valid bits and loads the configuration defaults (colon on, rest off).
// Top level of the clock digit formatter; depends on cdfuk_pkg and cdfuk_summer.
`timescale 1ns / 1ps
`default_nettype none

module clock_digit_formatter_with_uk_dst (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request: year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
   // second[37:32], net_online[38], zero[39].
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   // Response: hour_tens[1:0], hour_ones[5:2], blank_first[6], point_first[7],
   // minute_tens[10:8], minute_ones[14:11], point_last[15], colon_on[16],
   // led_update[17], led_level[18], summer_time[19], zero[23:20].
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,
   // Configuration port.
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [cdfuk_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers. The low address bits are ignored, so
   // the register index is the word address.
   // ---------------------------------------------------------------
   logic mode_24h_ff;
   logic dst_enable_ff;
   logic colon_enable_ff;
   logic colon_flash_ff;
   logic led_enable_ff;
   logic csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_24h_ff     <= 1'b0;
         dst_enable_ff   <= 1'b0;
         colon_enable_ff <= 1'b1;
         colon_flash_ff  <= 1'b0;
         led_enable_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            cdfuk_pkg::REG_MODE_24H:     mode_24h_ff     <= csr_pwdata[0];
            cdfuk_pkg::REG_DST_ENABLE:   dst_enable_ff   <= csr_pwdata[0];
            cdfuk_pkg::REG_COLON_ENABLE: colon_enable_ff <= csr_pwdata[0];
            cdfuk_pkg::REG_COLON_FLASH:  colon_flash_ff  <= csr_pwdata[0];
            cdfuk_pkg::REG_LED_ENABLE:   led_enable_ff   <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      case (csr_index)
         cdfuk_pkg::REG_MODE_24H:     csr_prdata[0] = mode_24h_ff;
         cdfuk_pkg::REG_DST_ENABLE:   csr_prdata[0] = dst_enable_ff;
         cdfuk_pkg::REG_COLON_ENABLE: csr_prdata[0] = colon_enable_ff;
         cdfuk_pkg::REG_COLON_FLASH:  csr_prdata[0] = colon_flash_ff;
         cdfuk_pkg::REG_LED_ENABLE:   csr_prdata[0] = led_enable_ff;
         default:                     csr_prdata    = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------
   // Request unpacking. The hour wraps modulo 24 and the minute is
   // clamped at 59 before anything else sees them.
   // ---------------------------------------------------------------
   logic [11:0] in_year;
   logic [3:0]  in_month;
   logic [4:0]  in_day;
   logic [4:0]  in_hour;
   logic [5:0]  in_minute;
   cdfuk_pkg::side_type side_in;

   always_comb begin
      in_year   = req_tdata[11:0];
      in_month  = req_tdata[15:12];
      in_day    = req_tdata[20:16];
      in_hour   = req_tdata[25:21];
      in_minute = req_tdata[31:26];
      side_in.hour   = (in_hour >= cdfuk_pkg::HOURS_PER_DAY) ?
                       (in_hour - cdfuk_pkg::HOURS_PER_DAY) : in_hour;
      side_in.minute = (in_minute > cdfuk_pkg::MINUTE_LAST) ?
                       cdfuk_pkg::MINUTE_LAST : in_minute;
      side_in.even   = ~req_tdata[32];
      side_in.online = req_tdata[38];
   end

   // ---------------------------------------------------------------
   // Pipeline control. Every stage loads together when the output
   // register is free or its result is being taken this cycle, so a
   // stall freezes everything and nothing is dropped or repeated.
   // ---------------------------------------------------------------
   logic advance;
   logic [3:0] valid_ff;
   logic out_valid_ff;
   cdfuk_pkg::side_type side_ff [4];

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[2:0], req_tvalid};
         out_valid_ff <= valid_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         side_ff[3] <= side_ff[2];
      end
   end

   // The summer-time decision runs alongside the first four stages and
   // is aligned with side_ff[3].
   logic summer;

   cdfuk_summer u_summer (
      .clock   (clock),
      .advance (advance),
      .year    (in_year),
      .month   (in_month),
      .day     (in_day),
      .summer  (summer)
   );

   // ---------------------------------------------------------------
   // Output stage: summer-time shift, 12/24-hour form, BCD digits and
   // the colon and LED indicators.
   // ---------------------------------------------------------------
   logic [4:0] hour_shift;
   logic [4:0] hour_disp;
   logic       pm;
   logic [1:0] hour_tens;
   logic [3:0] hour_ones;
   logic [10:0] min_prod;
   logic [2:0] minute_tens;
   logic [3:0] minute_ones;
   logic       colon_on;
   logic       led_update;
   logic [23:0] rsp_data_in;
   logic [23:0] rsp_data_ff;

   always_comb begin
      hour_shift = side_ff[3].hour;
      if (dst_enable_ff && summer) begin
         hour_shift = (side_ff[3].hour == cdfuk_pkg::HOUR_LAST) ? 5'd0 :
                      (side_ff[3].hour + 5'd1);
      end
      pm        = (hour_shift > cdfuk_pkg::HOUR_AM_LAST);
      hour_disp = hour_shift;
      if (!mode_24h_ff) begin
         if (pm) begin
            hour_disp = hour_shift - cdfuk_pkg::HOUR_NOON;
         end
         if (hour_disp == 5'd0) begin
            hour_disp = cdfuk_pkg::HOUR_NOON;
         end
      end
      if (hour_disp >= 5'd20) begin
         hour_tens = 2'd2;
      end else if (hour_disp >= 5'd10) begin
         hour_tens = 2'd1;
      end else begin
         hour_tens = 2'd0;
      end
      hour_ones = 4'(hour_disp - (5'(hour_tens) * 5'd10));

      // minute / 10 as (minute * 13) >> 7, exact for 0..63.
      min_prod    = {5'b0, side_ff[3].minute} * 11'd13;
      minute_tens = min_prod[9:7];
      minute_ones = 4'(side_ff[3].minute - (6'(minute_tens) * 6'd10));

      colon_on   = colon_enable_ff && (!colon_flash_ff || side_ff[3].even);
      led_update = colon_enable_ff && colon_flash_ff && led_enable_ff;

      rsp_data_in        = '0;
      rsp_data_in[1:0]   = hour_tens;
      rsp_data_in[5:2]   = hour_ones;
      rsp_data_in[6]     = !mode_24h_ff && (hour_disp < 5'd10);
      rsp_data_in[7]     = !side_ff[3].online;
      rsp_data_in[10:8]  = minute_tens;
      rsp_data_in[14:11] = minute_ones;
      rsp_data_in[15]    = !mode_24h_ff && pm;
      rsp_data_in[16]    = colon_on;
      rsp_data_in[17]    = led_update;
      rsp_data_in[18]    = led_update && side_ff[3].even;
      rsp_data_in[19]    = summer;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // In 12-hour form the shown hour is never zero.
   a_no_zero_hour_12h: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !mode_24h_ff) |-> (rsp_tdata[5:0] != 6'd0))
      else $error("12-hour display shows hour zero");

   // 24-hour form never blanks the first digit nor lights the PM point.
   a_24h_no_pm_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && mode_24h_ff) |-> (!rsp_tdata[6] && !rsp_tdata[15]))
      else $error("PM point or blank digit in 24-hour mode");

   // When the LED is driven it follows the flashing colon.
   a_led_follows_colon: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[17]) |-> (rsp_tdata[16] == rsp_tdata[18]))
      else $error("LED level differs from colon");

   // Minute digits stay decimal.
   a_minute_bcd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[10:8] <= 3'd5) && (rsp_tdata[14:11] <= 4'd9)))
      else $error("minute digits out of range");

   // A stalled pipeline must not take a new request.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request accepted while output stalled");
`endif

endmodule

`default_nettype wire
